>>> sv/crc8_frame_receiver_defines.svh
// Assertion macros for the checker file of the CRC-8 frame receiver.
`ifndef CRC8_FRAME_RECEIVER_DEFINES_SVH
`define CRC8_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CRC8FR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("crc8fr assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CRC8FR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("crc8fr assertion failed");

`endif

>>> sv/crc8fr_pkg.sv
// Types, constants and the CRC-8 byte update for the frame receiver.
package crc8fr_pkg;

  localparam logic [7:0] CrcPoly = 8'h07;
  localparam logic [7:0] CrcInit = 8'h00;

  localparam logic [7:0] StartMarkerReset = 8'hAA;
  localparam logic [7:0] EndMarkerReset   = 8'h55;

  // Configuration register indexes
  localparam logic CfgStartMarker = 1'b0;
  localparam logic CfgEndMarker   = 1'b1;

  // Frame byte positions after the start marker
  localparam logic [2:0] PosId   = 3'd1;
  localparam logic [2:0] PosPay0 = 3'd2;
  localparam logic [2:0] PosPay1 = 3'd3;
  localparam logic [2:0] PosPay2 = 3'd4;
  localparam logic [2:0] PosPay3 = 3'd5;
  localparam logic [2:0] PosCrc  = 3'd6;
  localparam logic [2:0] PosEnd  = 3'd7;

  typedef struct packed {
    logic clear;
    logic update;
  } crc_ctrl_t;

  // One byte through the MSB-first CRC-8 shift network.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

>>> sv/crc8fr_crc.sv
// Running CRC-8 register, cleared at frame start and updated per data byte.
module crc8fr_crc (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  crc8fr_pkg::crc_ctrl_t  ctrl_i,
  input  logic [7:0]             byte_i,
  output logic [7:0]             crc_o
);

  logic [7:0] crc_q, crc_d;

  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.clear) begin
      crc_d = crc8fr_pkg::CrcInit;
    end else if (ctrl_i.update) begin
      crc_d = crc8fr_pkg::crc8_step(crc_q, byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= crc8fr_pkg::CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

>>> sv/crc8_frame_receiver.sv
// A good frame's result shows on out_valid_o in the cycle after its end byte is taken.
// Throughput: one rx byte per cycle while in_ready_o is high; the CRC step is one unrolled XOR network per byte.
// in_ready_o drops only while a result waits in the output register and out_ready_i is low.
// Reset: idle, byte count and CRC cleared, no result pending, markers 0xAA / 0x55.
// Held frame fields carry no reset; each is written within a frame before it is read.
module crc8_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  msg_id_o,
  output logic [31:0] payload_o
);

  logic [7:0]  start_marker_q, end_marker_q;
  logic        in_frame_q, in_frame_d;
  logic [2:0]  pos_q, pos_d;
  logic [7:0]  held_id_q, held_id_d;
  logic [31:0] held_payload_q, held_payload_d;
  logic [7:0]  held_crc_q, held_crc_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  msg_id_q;
  logic [31:0] payload_q;
  logic        accept, emit;
  logic [7:0]  crc;
  crc8fr_pkg::crc_ctrl_t crc_ctrl;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  crc8fr_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .byte_i (rx_byte_i),
    .crc_o  (crc)
  );

  always_comb begin
    in_frame_d     = in_frame_q;
    pos_d          = pos_q;
    held_id_d      = held_id_q;
    held_payload_d = held_payload_q;
    held_crc_d     = held_crc_q;
    crc_ctrl       = '0;
    emit           = 1'b0;
    if (accept) begin
      if (!in_frame_q) begin
        if (rx_byte_i == start_marker_q) begin
          in_frame_d     = 1'b1;
          pos_d          = crc8fr_pkg::PosId;
          crc_ctrl.clear = 1'b1;
        end
      end else begin
        pos_d = pos_q + 3'd1;
        case (pos_q)
          crc8fr_pkg::PosId: begin
            held_id_d       = rx_byte_i;
            crc_ctrl.update = 1'b1;
          end
          crc8fr_pkg::PosPay0: begin
            held_payload_d[7:0] = rx_byte_i;
            crc_ctrl.update     = 1'b1;
          end
          crc8fr_pkg::PosPay1: begin
            held_payload_d[15:8] = rx_byte_i;
            crc_ctrl.update      = 1'b1;
          end
          crc8fr_pkg::PosPay2: begin
            held_payload_d[23:16] = rx_byte_i;
            crc_ctrl.update       = 1'b1;
          end
          crc8fr_pkg::PosPay3: begin
            held_payload_d[31:24] = rx_byte_i;
            crc_ctrl.update       = 1'b1;
          end
          crc8fr_pkg::PosCrc: begin
            held_crc_d = rx_byte_i;
          end
          crc8fr_pkg::PosEnd: begin
            in_frame_d = 1'b0;
            pos_d      = 3'd0;
            emit       = (rx_byte_i == end_marker_q) && (crc == held_crc_q);
          end
          default: begin
            // count of zero inside a frame: just advance
          end
        endcase
      end
    end
  end

  assign out_valid_d = emit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= crc8fr_pkg::StartMarkerReset;
      end_marker_q   <= crc8fr_pkg::EndMarkerReset;
      in_frame_q     <= 1'b0;
      pos_q          <= 3'd0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == crc8fr_pkg::CfgStartMarker) begin
          start_marker_q <= cfg_data_i;
        end
        if (cfg_idx_i == crc8fr_pkg::CfgEndMarker) begin
          end_marker_q <= cfg_data_i;
        end
      end
      in_frame_q  <= in_frame_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_id_q      <= held_id_d;
    held_payload_q <= held_payload_d;
    held_crc_q     <= held_crc_d;
    if (emit) begin
      msg_id_q  <= held_id_q;
      payload_q <= held_payload_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign msg_id_o    = msg_id_q;
  assign payload_o   = payload_q;

endmodule

>>> sv/crc8fr_checker.sv
// Port-level checker for the CRC-8 frame receiver, bound to the top level.
`include "crc8_frame_receiver_defines.svh"

module crc8fr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  msg_id_o,
  input logic [31:0] payload_o
);

  // a waiting result is never dropped
  `CRC8FR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  // a stalled result blocks new bytes
  `CRC8FR_ASSERT_SAME(a_backpressure, out_valid_o && !out_ready_i, !in_ready_o)
  // with no result pending the block always takes bytes
  `CRC8FR_ASSERT_SAME(a_free_ready, !out_valid_o, in_ready_o)
  // a new result only follows a byte transaction
  `CRC8FR_ASSERT_SAME(a_cause, $rose(out_valid_o), $past(in_valid_i && in_ready_o))
  // result fields stay put while stalled
  `CRC8FR_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i,
                      $stable(msg_id_o) && $stable(payload_o))

endmodule

bind crc8_frame_receiver crc8fr_checker u_checker (.*);

>>> sim/crc8_frame_receiver_test.sv
// Self-checking testbench for the CRC-8 frame receiver: directed frames, then random frames.
`timescale 1ns / 100ps

module crc8_frame_receiver_test;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] pay;
  } frame_result_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_RESULT,
    ROW_SILENT
  } row_kind_e;

  typedef struct packed {
    logic [7:0]  rx;
    row_kind_e   kind;
    logic [7:0]  id;
    logic [31:0] pay;
  } directed_row_t;

  localparam int NumDirected = 25;
  localparam int HoldCycles  = 400;
  localparam int DrainLimit  = 5000;

  // Reset markers are 0xAA / 0x55 during the directed part.
  localparam directed_row_t DirectedRows [NumDirected] = '{
    '{8'h3C, ROW_PREDICT, 8'h00, 32'h0},
    // all-zero frame: CRC of zeros is zero
    '{8'hAA, ROW_PREDICT, 8'h00, 32'h0},
    '{8'h00, ROW_PREDICT, 8'h00, 32'h0},
    '{8'h00, ROW_PREDICT, 8'h00, 32'h0},
    '{8'h00, ROW_PREDICT, 8'h00, 32'h0},
    '{8'h00, ROW_PREDICT, 8'h00, 32'h0},
    '{8'h00, ROW_PREDICT, 8'h00, 32'h0},
    '{8'h00, ROW_PREDICT, 8'h00, 32'h0},
    '{8'h55, ROW_RESULT,  8'h00, 32'h0},
    // start marker as id, all-ones payload
    '{8'hAA, ROW_PREDICT, 8'h00, 32'h0},
    '{8'hAA, ROW_PREDICT, 8'h00, 32'h0},
    '{8'hFF, ROW_PREDICT, 8'h00, 32'h0},
    '{8'hFF, ROW_PREDICT, 8'h00, 32'h0},
    '{8'hFF, ROW_PREDICT, 8'h00, 32'h0},
    '{8'hFF, ROW_PREDICT, 8'h00, 32'h0},
    '{8'hF0, ROW_PREDICT, 8'h00, 32'h0},
    '{8'h55, ROW_PREDICT, 8'h00, 32'h0},
    // good CRC but wrong end marker: dropped
    '{8'hAA, ROW_PREDICT, 8'h00, 32'h0},
    '{8'h00, ROW_PREDICT, 8'h00, 32'h0},
    '{8'h00, ROW_PREDICT, 8'h00, 32'h0},
    '{8'h00, ROW_PREDICT, 8'h00, 32'h0},
    '{8'h00, ROW_PREDICT, 8'h00, 32'h0},
    '{8'h00, ROW_PREDICT, 8'h00, 32'h0},
    '{8'h00, ROW_PREDICT, 8'h00, 32'h0},
    '{8'h54, ROW_SILENT,  8'h00, 32'h0}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = crc8fr_pkg::CfgStartMarker;
  logic [7:0]  cfg_data_i  = 8'h00;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  msg_id_o;
  logic [31:0] payload_o;

  crc8_frame_receiver i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .rx_byte_i,
    .out_valid_o,
    .out_ready_i,
    .msg_id_o,
    .payload_o
  );

  always #5 clk_i = ~clk_i;

  // Deframer mirror
  logic [7:0]  start_mk = crc8fr_pkg::StartMarkerReset;
  logic [7:0]  end_mk   = crc8fr_pkg::EndMarkerReset;
  logic        in_frame = 1'b0;
  logic [2:0]  frame_pos = 3'd0;
  logic [7:0]  crc_acc = crc8fr_pkg::CrcInit;
  logic [7:0]  id_hold = 8'h00;
  logic [31:0] pay_hold = 32'h0;
  logic [7:0]  crc_hold = 8'h00;

  frame_result_t pending_results [$];
  frame_result_t oldest;
  int            mismatches   = 0;
  int            results_seen = 0;
  int            tx_idle_pct  = 18;
  int            rx_idle_pct  = 69;
  int            frame_bytes  = 0;
  bit            hold_used    = 1'b0;

  function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ crc8fr_pkg::CrcPoly) : {r[6:0], 1'b0};
    return r;
  endfunction

  // Advances the mirror by one byte; returns 1 when a good frame completes.
  function automatic logic deframe_byte(input logic [7:0] b, output frame_result_t res);
    logic good;
    good = 1'b0;
    if (!in_frame) begin
      if (b == start_mk) begin
        in_frame  = 1'b1;
        frame_pos = crc8fr_pkg::PosId;
        crc_acc   = crc8fr_pkg::CrcInit;
      end
    end else begin
      case (frame_pos)
        crc8fr_pkg::PosId: begin
          id_hold = b;
          crc_acc = crc_fold(crc_acc, b);
        end
        crc8fr_pkg::PosPay0, crc8fr_pkg::PosPay1,
        crc8fr_pkg::PosPay2, crc8fr_pkg::PosPay3: begin
          pay_hold[8 * int'(frame_pos - crc8fr_pkg::PosPay0) +: 8] = b;
          crc_acc = crc_fold(crc_acc, b);
        end
        crc8fr_pkg::PosCrc: crc_hold = b;
        crc8fr_pkg::PosEnd: begin
          in_frame = 1'b0;
          good = (b == end_mk) && (crc_acc == crc_hold);
        end
        default: ;
      endcase
      frame_pos = (frame_pos == crc8fr_pkg::PosEnd) ? 3'd0 : frame_pos + 3'd1;
    end
    res = '{id: id_hold, pay: pay_hold};
    return good;
  endfunction

  task automatic report_miss(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // One rx transaction; returns at the accepting edge.
  task automatic push_rx(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_checked(input logic [7:0] b);
    frame_result_t res;
    push_rx(b);
    if (deframe_byte(b, res)) pending_results.push_back(res);
  endtask

  task automatic send_random_frame();
    logic [7:0] fb [8];
    logic [7:0] crc;
    int         cut;
    fb[0] = start_mk;
    crc = crc8fr_pkg::CrcInit;
    for (int k = 1; k < 6; k++) begin
      case ($urandom_range(7))
        0:       fb[k] = start_mk;
        1:       fb[k] = 8'h00;
        2:       fb[k] = 8'hFF;
        default: fb[k] = 8'($urandom_range(255));
      endcase
      crc = crc_fold(crc, fb[k]);
    end
    fb[6] = crc;
    fb[7] = end_mk;
    cut = 8;
    case ($urandom_range(15))
      0:       fb[6] = crc ^ 8'($urandom_range(1, 255));
      1:       fb[7] = end_mk ^ 8'($urandom_range(1, 255));
      2:       cut = $urandom_range(1, 7);
      default: ;
    endcase
    for (int k = 0; k < cut; k++) send_checked(fb[k]);
    frame_bytes += cut;
  endtask

  // Stop offering, let every expected result arrive, then let the pipe settle.
  task automatic drain_results();
    int            n;
    frame_result_t lost;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    n = 0;
    while (pending_results.size() != 0 && n < DrainLimit) begin
      @(posedge clk_i);
      n++;
    end
    while (pending_results.size() != 0) begin
      lost = pending_results.pop_front();
      report_miss($sformatf("missing result id %h payload %h", lost.id, lost.pay));
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_markers(input logic [7:0] s, input logic [7:0] e);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= crc8fr_pkg::CfgStartMarker;
    cfg_data_i <= s;
    @(negedge clk_i);
    cfg_idx_i  <= crc8fr_pkg::CfgEndMarker;
    cfg_data_i <= e;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    start_mk = s;
    end_mk   = e;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_miss($sformatf("unexpected result id %h payload %h", msg_id_o, payload_o));
      end else begin
        oldest = pending_results.pop_front();
        if (msg_id_o !== oldest.id)
          report_miss($sformatf("msg_id exp %h got %h", oldest.id, msg_id_o));
        if (payload_o !== oldest.pay)
          report_miss($sformatf("payload exp %h got %h", oldest.pay, payload_o));
      end
    end
  end

  // Result receiver; one long hold-off lets the block back up into its input.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (!hold_used && results_seen >= 12) begin
        hold_used = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : stimulus
    frame_result_t res;
    int            phase_bytes;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < 4; p++) begin
      case (p)
        0, 1: begin
          tx_idle_pct = 18;
          rx_idle_pct = 69;
        end
        2: begin
          tx_idle_pct = 69;
          rx_idle_pct = 18;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase

      case (p)
        0: begin
          foreach (DirectedRows[r]) begin
            push_rx(DirectedRows[r].rx);
            if (deframe_byte(DirectedRows[r].rx, res) && DirectedRows[r].kind == ROW_PREDICT)
              pending_results.push_back(res);
            if (DirectedRows[r].kind == ROW_RESULT)
              pending_results.push_back('{id: DirectedRows[r].id, pay: DirectedRows[r].pay});
          end
        end
        1: begin
          drain_results();
          write_markers(8'h00, 8'hFF);
        end
        2: begin
          drain_results();
          write_markers(8'hFF, 8'h00);
        end
        default: begin
          drain_results();
          write_markers(8'($urandom_range(255)), 8'($urandom_range(255)));
        end
      endcase

      phase_bytes = (p == 0) ? 180 : 180;
      frame_bytes = 0;
      while (frame_bytes < phase_bytes) begin
        if ($urandom_range(4) == 0) begin
          // line noise between frames
          repeat ($urandom_range(1, 4)) send_checked(8'($urandom_range(255)));
        end else begin
          send_random_frame();
        end
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("crc8_frame_receiver_test: done, clean");
    end else begin
      $display("crc8_frame_receiver_test: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(2_000_000);
    $display("crc8_frame_receiver_test: done, errors");
    $finish;
  end

endmodule
